// File: rtl/srrs_pkg.sv
// Shared constants, result type and rate table of the sine rate/ratio search.
package srrs_pkg;

	// Search limits
	localparam int TABLE_LEN_LIMIT = 4096;
	localparam int RATE_COUNT      = 10;
	localparam int RATE_IDX_W      = 4;

	// Field widths
	localparam int LEN_W     = 13;
	localparam int MSPC_W    = 16;
	localparam int REQ_W     = 32;
	localparam int FS_W      = 18;
	localparam int FRAC_BITS = 14;
	localparam int DEN_W     = FS_W + FRAC_BITS;

	// Whole periods of the lowest rate that fit in one request step
	localparam int QUO_W = 5;
	// K before the samples-per-cycle check; stays below 27 * 4096
	localparam int KW    = 17;
	localparam int MQ_W  = MSPC_W + QUO_W;
	localparam int MK_W  = MSPC_W + KW + 1;

	// Shared multiplier
	localparam int MUL_A_W = REQ_W;
	localparam int MUL_B_W = LEN_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TABLE_LEN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPC       = 1'd1;
	localparam logic [LEN_W-1:0]     MAX_TABLE_LEN_RST = 13'd4096;
	localparam logic [MSPC_W-1:0]    MIN_SPC_RST       = 16'd512;
	localparam logic [MSPC_W-1:0]    MIN_SPC_ONE       = 16'd256;

	// One plan, ok in the lowest bit
	typedef struct packed {
		logic [REQ_W-1:0] actual_hz;
		logic [LEN_W-1:0] table_len;
		logic [LEN_W-1:0] cycles_k;
		logic [FS_W-1:0]  sample_rate_hz;
		logic             ok;
	} plan_t;

	localparam int PLAN_W      = $bits(plan_t);
	// ok travels on tuser, the other fields fill tdata
	localparam int OUT_DATA_W  = PLAN_W - 1;
	localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

	// Sample rates in Hz, fastest first; unused slots hold zero
	function automatic logic [FS_W-1:0] rate_hz(input logic [RATE_IDX_W-1:0] idx);
		logic [FS_W-1:0] fs;
		unique case (idx)
			4'd0:    fs = 18'd156250;
			4'd1:    fs = 18'd125000;
			4'd2:    fs = 18'd78125;
			4'd3:    fs = 18'd62500;
			4'd4:    fs = 18'd50000;
			4'd5:    fs = 18'd31250;
			4'd6:    fs = 18'd25000;
			4'd7:    fs = 18'd15625;
			4'd8:    fs = 18'd12500;
			4'd9:    fs = 18'd10000;
			default: fs = '0;
		endcase
		return fs;
	endfunction

endpackage

// File: rtl/srrs_divider.sv
// Restoring divider, one quotient bit per cycle, for the final frequency.
module srrs_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [srrs_pkg::PROD_W-1:0] dividend,
	input  logic [srrs_pkg::LEN_W-1:0]  divisor,
	output logic                        done,
	output logic [srrs_pkg::REQ_W-1:0]  quotient
);
	import srrs_pkg::*;

	localparam int CNT_W = $clog2(REQ_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] div_q;
	logic [REQ_W-1:0] quo_q;

	logic [LEN_W:0]   rem_sh;
	logic             fits;

	// Shift in the next dividend bit and try a subtract
	assign rem_sh = {rem_q, quo_q[REQ_W-1]};
	assign fits   = rem_sh >= {1'b0, div_q};

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(REQ_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath; the upper dividend bits are already below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_W-1:REQ_W];
			quo_q <= dividend[REQ_W-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? LEN_W'(rem_sh - {1'b0, div_q}) : rem_sh[LEN_W-1:0];
			quo_q <= {quo_q[REQ_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/srrs_search.sv
// Sequencer and shared datapath that walk the rate and length candidates until an exact hit.
module srrs_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [srrs_pkg::REQ_W-1:0]  req,
	input  logic [srrs_pkg::LEN_W-1:0]  max_len,
	input  logic [srrs_pkg::MSPC_W-1:0] min_spc,
	output logic                        idle,
	output logic                        res_valid,
	output srrs_pkg::plan_t             res,
	input  logic                        res_take
);
	import srrs_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_RATE = 10'b00_0000_0010,
		S_QDIV = 10'b00_0000_0100,
		S_MQ   = 10'b00_0000_1000,
		S_STEP = 10'b00_0001_0000,
		S_CMPA = 10'b00_0010_0000,
		S_CMPB = 10'b00_0100_0000,
		S_FMUL = 10'b00_1000_0000,
		S_FDIV = 10'b01_0000_0000,
		S_DONE = 10'b10_0000_0000
	} srch_state_t;

	srch_state_t state_q, state_d;
	logic        found_q;

	// Request and settings held for the whole search
	logic [REQ_W-1:0]      req_q;
	logic [MSPC_W-1:0]     m_q;
	logic [LEN_W-1:0]      lmax_q;
	// Per-rate values
	logic [RATE_IDX_W-1:0] ri_q;
	logic [FS_W-1:0]       fs_q;
	logic [DEN_W-1:0]      d_q;
	logic [REQ_W-1:0]      rem_q;
	logic [QUO_W-1:0]      q_q;
	logic [MQ_W-1:0]       mq_q;
	// Running candidate
	logic [LEN_W-1:0]      l_q;
	logic [DEN_W-1:0]      r_q;
	logic [KW-1:0]         k_q;
	logic [MK_W-1:0]       mk_q;
	logic [DEN_W-1:0]      n_q;
	logic [PROD_W-1:0]     a_q;
	// Best so far
	logic [DEN_W-1:0]      best_n_q;
	logic [LEN_W-1:0]      best_l_q;
	logic [KW-1:0]         best_k_q;
	logic [DEN_W-1:0]      best_d_q;
	logic [FS_W-1:0]       best_fs_q;
	logic [REQ_W-1:0]      actual_q;

	logic [LEN_W-1:0]   lmax_in;
	logic               bad_req;
	logic [FS_W-1:0]    fs_sel;
	logic [DEN_W:0]     sum;
	logic               carry;
	logic [DEN_W-1:0]   r_adv;
	logic [KW-1:0]      k_adv;
	logic [MK_W-1:0]    mk_adv;
	logic [DEN_W-1:0]   half;
	logic [DEN_W-1:0]   n_cur;
	logic               skip;
	logic               len_end;
	logic               last_rate;
	logic               better;
	logic               hit;
	logic               found_nx;
	srch_state_t        fin_state;
	srch_state_t        after_len;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic               div_start;
	logic               div_done;
	logic [REQ_W-1:0]   div_quo;

	// Settings check at start
	assign lmax_in = (max_len > LEN_W'(TABLE_LEN_LIMIT)) ? LEN_W'(TABLE_LEN_LIMIT) : max_len;
	assign bad_req = (req == '0) || (lmax_in < LEN_W'(2)) || (min_spc < MIN_SPC_ONE);

	assign fs_sel = rate_hz(ri_q);

	// Next length: K and its rounding remainder move by the per-rate quotient
	assign sum    = {1'b0, r_q} + {1'b0, rem_q};
	assign carry  = sum >= {1'b0, d_q};
	assign r_adv  = carry ? DEN_W'(sum - {1'b0, d_q}) : sum[DEN_W-1:0];
	assign k_adv  = k_q + KW'(q_q) + KW'(carry);
	assign mk_adv = mk_q + MK_W'(mq_q) + (carry ? MK_W'(m_q) : '0);

	// Error numerator is the distance of the remainder from half a period
	assign half  = {1'b0, d_q[DEN_W-1:1]};
	assign n_cur = (half >= r_q) ? half - r_q : r_q - half;

	// K of zero or too few samples per cycle
	assign skip      = (k_q == '0) || (MK_W'({l_q, 8'd0}) < mk_q);
	assign len_end   = l_q == lmax_q;
	assign last_rate = ri_q == RATE_IDX_W'(RATE_COUNT - 1);

	// Shared multiplier
	always_comb begin
		unique case (state_q)
			S_MQ: begin
				mul_a = MUL_A_W'(m_q);
				mul_b = MUL_B_W'(q_q);
			end
			S_CMPA: begin
				mul_a = n_cur;
				mul_b = best_l_q;
			end
			S_CMPB: begin
				mul_a = best_n_q;
				mul_b = l_q;
			end
			S_FMUL: begin
				mul_a = best_d_q;
				mul_b = best_k_q[LEN_W-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Cross-multiplied error compare
	assign better   = !found_q || (a_q < prod);
	assign hit      = better && (n_q == '0);
	assign found_nx = found_q || ((state_q == S_CMPB) && better);

	assign fin_state = found_nx ? S_FMUL : S_DONE;
	assign after_len = last_rate ? fin_state : S_RATE;

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start)
					state_d = bad_req ? S_DONE : S_RATE;
			end
			S_RATE: begin
				if (fs_sel == '0)
					state_d = after_len;
				else
					state_d = S_QDIV;
			end
			S_QDIV: begin
				if (rem_q < d_q)
					state_d = S_MQ;
			end
			S_MQ: begin
				state_d = S_STEP;
			end
			S_STEP: begin
				state_d = S_CMPA;
			end
			S_CMPA: begin
				if (!skip)
					state_d = S_CMPB;
				else if (len_end)
					state_d = after_len;
			end
			S_CMPB: begin
				if (hit)
					state_d = S_FMUL;
				else if (len_end)
					state_d = after_len;
				else
					state_d = S_CMPA;
			end
			S_FMUL: begin
				state_d = S_FDIV;
			end
			S_FDIV: begin
				if (div_done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (res_take)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start)
				found_q <= 1'b0;
			else if (state_q == S_CMPB && better)
				found_q <= 1'b1;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q    <= req;
			m_q      <= min_spc;
			lmax_q   <= lmax_in;
			ri_q     <= '0;
			best_l_q <= LEN_W'(1);
		end
		if (state_d == S_RATE && state_q != S_IDLE)
			ri_q <= ri_q + 1'b1;
		if (state_q == S_RATE) begin
			fs_q  <= fs_sel;
			d_q   <= {fs_sel, {FRAC_BITS{1'b0}}};
			rem_q <= req_q;
			q_q   <= '0;
		end
		// Request step split into whole periods and a remainder
		if (state_q == S_QDIV && rem_q >= d_q) begin
			rem_q <= rem_q - d_q;
			q_q   <= q_q + 1'b1;
		end
		// Length zero: K is zero and the remainder sits at half a period
		if (state_q == S_MQ) begin
			mq_q <= prod[MQ_W-1:0];
			l_q  <= '0;
			r_q  <= half;
			k_q  <= '0;
			mk_q <= '0;
		end
		if (state_d == S_CMPA) begin
			l_q  <= l_q + 1'b1;
			r_q  <= r_adv;
			k_q  <= k_adv;
			mk_q <= mk_adv;
		end
		if (state_q == S_CMPA && !skip) begin
			n_q <= n_cur;
			a_q <= prod;
		end
		if (state_q == S_CMPB && better) begin
			best_n_q  <= n_q;
			best_l_q  <= l_q;
			best_k_q  <= k_q;
			best_d_q  <= d_q;
			best_fs_q <= fs_q;
		end
		if (state_q == S_FDIV && div_done)
			actual_q <= div_quo;
	end

	assign div_start = state_q == S_FMUL;

	srrs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (best_l_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Result, all zero when nothing was found
	always_comb begin
		res.ok             = found_q;
		res.sample_rate_hz = found_q ? best_fs_q : '0;
		res.cycles_k       = found_q ? best_k_q[LEN_W-1:0] : '0;
		res.table_len      = found_q ? best_l_q : '0;
		res.actual_hz      = found_q ? actual_q : '0;
	end

	assign res_valid = state_q == S_DONE;
	assign idle      = state_q == S_IDLE;

endmodule

// File: rtl/sine_rate_ratio_search_core.sv
// Top level of the sine rate/ratio search: stream ports, settings, result register.
//
// Takes a sine frequency request (unsigned Q18.14 Hz) and returns one plan: the
// sample rate, K periods and table length L whose rate*K/L is closest to the
// request, with the resulting frequency. Rates are searched fastest first and
// L from 1 to max_table_len; the first exact hit ends the search. For each rate
// the request is divided by 16384*rate by repeated subtraction (quotient at
// most 26), then the lengths are stepped and, unless skipped, tested. The
// search shares one multiplier, which every tested length uses twice for the
// cross-multiplied error compare, and ends with the bit-serial divider when a
// plan is found. An invalid request goes from idle straight to the result, with
// no search. The input is not ready while a search runs; a finished plan waits
// in the output register while the next request is taken. The ok flag travels
// on tuser.
module sine_rate_ratio_search_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// requested_hz [31:0]
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [srrs_pkg::REQ_W-1:0]       s_axis_tdata,
	// sample_rate_hz [17:0], cycles_k [30:18], table_len [43:31],
	// actual_hz [75:44], zero [79:76]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [srrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// ok [0]
	output logic                             m_axis_tuser,
	input  logic                             cfg_we,
	input  logic [srrs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [srrs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import srrs_pkg::*;

	logic [LEN_W-1:0]  max_table_len_q;
	logic [MSPC_W-1:0] min_spc_q;
	logic              out_valid_q;
	plan_t             out_plan_q;

	logic  srch_idle;
	logic  start;
	logic  res_valid;
	logic  res_take;
	plan_t res;

	// Settings registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_table_len_q <= MAX_TABLE_LEN_RST;
			min_spc_q       <= MIN_SPC_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_TABLE_LEN: max_table_len_q <= cfg_data[LEN_W-1:0];
				REG_MIN_SPC:       min_spc_q       <= cfg_data[MSPC_W-1:0];
			endcase
		end
	end

	assign s_axis_tready = srch_idle;
	assign start         = s_axis_tvalid && s_axis_tready;
	assign res_take      = !out_valid_q || m_axis_tready;

	srrs_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (s_axis_tdata),
		.max_len   (max_table_len_q),
		.min_spc   (min_spc_q),
		.idle      (srch_idle),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_valid && res_take)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take)
			out_plan_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_DATA_W){1'b0}}, out_plan_q[PLAN_W-1:1]};
	assign m_axis_tuser  = out_plan_q.ok;

	// A taken request closes the input in the next cycle
	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !s_axis_tready)
		else $error("input ready right after a request was taken");

	// No plan means every other field is zero
	a_empty_plan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_plan_q.ok |->
			out_plan_q.sample_rate_hz == '0 && out_plan_q.cycles_k == '0 &&
			out_plan_q.table_len == '0 && out_plan_q.actual_hz == '0)
		else $error("failed plan carries nonzero fields");

	// A plan has a rate, at least one period and no more periods than samples
	a_plan_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_plan_q.ok |->
			out_plan_q.sample_rate_hz != '0 && out_plan_q.cycles_k != '0 &&
			out_plan_q.cycles_k <= out_plan_q.table_len)
		else $error("plan with bad rate, K or L");

endmodule
